// ===== rtl/npmt_pkg.sv =====
// Shared types and constants for the named position mark table.
// Holds the input and result beat formats, opcodes and the internal command format.
// No dependencies.
package npmt_pkg;

  localparam int NAME_W  = 8;
  localparam int FIELD_W = 16;

  // Request opcodes
  localparam logic [2:0] OP_SET_MARK   = 3'd0;
  localparam logic [2:0] OP_SET_PREV   = 3'd1;
  localparam logic [2:0] OP_GET        = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL  = 3'd3;
  localparam logic [2:0] OP_CLEAR_LINE = 3'd4;

  // Special mark names
  localparam logic [NAME_W-1:0] NAME_NONE  = 8'h00;
  localparam logic [NAME_W-1:0] NAME_QUOTE = 8'h27;
  localparam logic [NAME_W-1:0] NAME_TICK  = 8'h60;

  // Letter ranges accepted as mark names
  localparam logic [NAME_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [NAME_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [NAME_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [NAME_W-1:0] CHAR_LOWER_Z = 8'h7A;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [NAME_W-1:0]  mark_name;
    logic [FIELD_W-1:0] line_id;
    logic [FIELD_W-1:0] column;
  } in_beat_t;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] found_line;
    logic [FIELD_W-1:0] found_column;
  } out_beat_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SET,
    CMD_SET_PREV,
    CMD_GET_SLOT,
    CMD_GET_PREV,
    CMD_CLEAR_ALL,
    CMD_CLEAR_LINE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [NAME_W-1:0]  mark_name;
    logic [FIELD_W-1:0] line_id;
    logic [FIELD_W-1:0] column;
  } cmd_t;

endpackage

// ===== rtl/named_position_mark_table_core.sv =====
// Named position mark table: small associative store of named cursor marks.
// Top level; instantiates npmt_front, npmt_queue and npmt_back. Depends on npmt_pkg.
//
// Usage
//   Request channel (in_valid / in_stall / in_data): one beat per request with an
//   opcode, a mark name byte, a line handle and a column. A beat is taken on a rising
//   edge with in_valid high and in_stall low. in_stall rises only when the two-entry
//   command queue is full.
//   Result channel (out_valid / out_stall / out_data): exactly one result beat per
//   request, in request order. A result is held in the output register, unchanged,
//   while out_stall is high; requests keep entering the queue meanwhile.
//
// Throughput
//   Requests that need no table scan (set previous-context, get of the quote or
//   backtick mark, clear all, set with a non-letter name, get of name zero, unknown
//   opcodes) run at one per cycle while out_stall is low.
//   Set mark, get of a named slot and clear line walk the slot memory through its
//   single read port, one slot per cycle; the back end starts no other request
//   until the walk is over, though new requests still enter the queue.
//
// Reset
//   Synchronous, active low. All slots become free, the previous-context mark becomes
//   invalid, the queue empties and no result is pending. No clearing pass is needed.
module named_position_mark_table_core #(
  parameter int MARK_SLOTS  = 10,
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  npmt_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output npmt_pkg::out_beat_t out_data
);
  import npmt_pkg::*;

  // front -> queue
  logic q_push;
  logic q_full;
  cmd_t q_cmd;

  // queue -> back
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  // Front decodes opcode and name into a command kind; no state.
  npmt_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Decouples request acceptance from a scan in progress.
  npmt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Back executes commands against the slot store and owns the result register.
  npmt_back #(
    .MARK_SLOTS  (MARK_SLOTS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/npmt_front.sv =====
// Front end of the mark table: accepts request beats and classifies them into commands.
// Depends on npmt_pkg.
module npmt_front (
  input  logic              in_valid,
  input  npmt_pkg::in_beat_t in_data,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output npmt_pkg::cmd_t    q_cmd
);
  import npmt_pkg::*;

  logic      is_letter;
  cmd_kind_t kind;

  always_comb begin
    is_letter = in_data.mark_name inside {[CHAR_UPPER_A:CHAR_UPPER_Z],
                                          [CHAR_LOWER_A:CHAR_LOWER_Z]};
    case (in_data.opcode)
      OP_SET_MARK: begin
        kind = is_letter ? CMD_SET : CMD_NOP;
      end
      OP_SET_PREV: begin
        kind = CMD_SET_PREV;
      end
      OP_GET: begin
        if (in_data.mark_name == NAME_QUOTE || in_data.mark_name == NAME_TICK) begin
          kind = CMD_GET_PREV;
        end else if (in_data.mark_name == NAME_NONE) begin
          kind = CMD_NOP;  // name zero never matches
        end else begin
          kind = CMD_GET_SLOT;
        end
      end
      OP_CLEAR_ALL: begin
        kind = CMD_CLEAR_ALL;
      end
      OP_CLEAR_LINE: begin
        kind = CMD_CLEAR_LINE;
      end
      default: begin
        kind = CMD_NOP;
      end
    endcase
  end

  always_comb begin
    q_cmd.kind      = kind;
    q_cmd.mark_name = in_data.mark_name;
    q_cmd.line_id   = in_data.line_id;
    q_cmd.column    = in_data.column;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

endmodule

// ===== rtl/npmt_queue.sv =====
// Short command queue between the front and back of the mark table.
// Depends on npmt_pkg.
module npmt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  npmt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output npmt_pkg::cmd_t head
);
  import npmt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/npmt_back.sv =====
// Back end of the mark table: slot store, previous-context register, slot scan
// sequencer and result register. Depends on npmt_pkg.
module npmt_back #(
  parameter int MARK_SLOTS  = 10,
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  npmt_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output npmt_pkg::out_beat_t out_data
);
  import npmt_pkg::*;

  localparam int IDX_W = (MARK_SLOTS > 1) ? $clog2(MARK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MARK_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r;

  // slot store; free slots are tracked by valid bits only
  logic [MARK_SLOTS-1:0]  valid_r;
  logic [NAME_W-1:0]      name_mem [MARK_SLOTS];
  logic [LINE_BITS-1:0]   line_mem [MARK_SLOTS];
  logic [COLUMN_BITS-1:0] col_mem  [MARK_SLOTS];
  logic [NAME_W-1:0]      rd_name_r;
  logic [LINE_BITS-1:0]   rd_line_r;
  logic [COLUMN_BITS-1:0] rd_col_r;

  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_act_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             chk_vld_r;

  logic                   hit_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic                   free_r;
  logic [IDX_W-1:0]       free_idx_r;
  logic [LINE_BITS-1:0]   get_line_r;
  logic [COLUMN_BITS-1:0] get_col_r;

  logic [LINE_BITS-1:0]   prev_line_r;
  logic [COLUMN_BITS-1:0] prev_col_r;
  logic                   prev_valid_r;

  logic      out_valid_r;
  out_beat_t out_data_r;

  logic                   pop_ok;
  logic                   needs_scan;
  logic [LINE_BITS-1:0]   head_line;
  logic [COLUMN_BITS-1:0] head_col;
  logic [LINE_BITS-1:0]   cmd_line;
  logic [COLUMN_BITS-1:0] cmd_col;
  logic                   slot_match;
  logic                   slot_free;
  logic                   line_match;
  logic                   scan_last;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  out_beat_t              imm_res;
  out_beat_t              fin_res;

  assign head_line  = LINE_BITS'(q_head.line_id);
  assign head_col   = COLUMN_BITS'(q_head.column);
  assign cmd_line   = LINE_BITS'(cmd_r.line_id);
  assign cmd_col    = COLUMN_BITS'(cmd_r.column);
  assign needs_scan = q_head.kind inside {CMD_SET, CMD_GET_SLOT, CMD_CLEAR_LINE};
  assign pop_ok     = (state_r == ST_IDLE) && q_valid && (!out_valid_r || !out_stall);
  assign q_pop      = pop_ok;

  assign slot_match = chk_vld_r && valid_r[chk_idx_r] && (rd_name_r == cmd_r.mark_name);
  assign slot_free  = chk_vld_r && !valid_r[chk_idx_r];
  assign line_match = chk_vld_r && valid_r[chk_idx_r] && (rd_line_r == cmd_line);
  assign scan_last  = chk_vld_r && (chk_idx_r == LAST_IDX);

  assign mem_we    = (state_r == ST_FIN) && (cmd_r.kind == CMD_SET) && (hit_r || free_r);
  assign mem_waddr = hit_r ? hit_idx_r : free_idx_r;

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = (pop_ok && needs_scan) ? ST_SCAN : ST_IDLE;
      ST_SCAN: state_nxt = scan_last ? ST_FIN : ST_SCAN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // results that need no scan
  always_comb begin
    imm_res = '0;
    case (q_head.kind)
      CMD_SET_PREV: begin
        imm_res.ok = 1'b1;
      end
      CMD_GET_PREV: begin
        if (prev_valid_r) begin
          imm_res.ok           = 1'b1;
          imm_res.found_line   = FIELD_W'(prev_line_r);
          imm_res.found_column = FIELD_W'(prev_col_r);
        end
      end
      default: begin
        imm_res = '0;
      end
    endcase
  end

  // results at the end of a scan
  always_comb begin
    fin_res = '0;
    case (cmd_r.kind)
      CMD_SET: begin
        fin_res.ok = hit_r | free_r;
      end
      CMD_GET_SLOT: begin
        if (hit_r) begin
          fin_res.ok           = 1'b1;
          fin_res.found_line   = FIELD_W'(get_line_r);
          fin_res.found_column = FIELD_W'(get_col_r);
        end
      end
      default: begin
        fin_res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_act_r     <= 1'b0;
      chk_vld_r    <= 1'b0;
      valid_r      <= '0;
      prev_valid_r <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= (state_r == ST_SCAN) && rd_act_r;

      if (pop_ok) begin
        rd_act_r <= needs_scan;
      end else if (state_r == ST_SCAN && rd_act_r && rd_idx_r == LAST_IDX) begin
        rd_act_r <= 1'b0;
      end

      if (pop_ok) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        if (slot_match && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (slot_free && !free_r) begin
          free_r <= 1'b1;
        end
      end

      if (pop_ok && q_head.kind == CMD_CLEAR_ALL) begin
        valid_r <= '0;
      end else if (state_r == ST_SCAN && cmd_r.kind == CMD_CLEAR_LINE && line_match) begin
        valid_r[chk_idx_r] <= 1'b0;
      end else if (mem_we && !hit_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end

      if (pop_ok) begin
        case (q_head.kind)
          CMD_SET_PREV:   prev_valid_r <= 1'b1;
          CMD_CLEAR_ALL:  prev_valid_r <= 1'b0;
          CMD_CLEAR_LINE: begin
            if (prev_line_r == head_line) begin
              prev_valid_r <= 1'b0;
            end
          end
          default:        prev_valid_r <= prev_valid_r;
        endcase
      end

      if (pop_ok && !needs_scan) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_FIN) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    chk_idx_r <= rd_idx_r;
    if (pop_ok) begin
      cmd_r    <= q_head;
      rd_idx_r <= '0;
      if (q_head.kind == CMD_SET_PREV) begin
        prev_line_r <= head_line;
        prev_col_r  <= head_col;
      end
    end else if (state_r == ST_SCAN && rd_act_r && rd_idx_r != LAST_IDX) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end

    if (state_r == ST_SCAN) begin
      if (slot_match && !hit_r) begin
        hit_idx_r  <= chk_idx_r;
        get_line_r <= rd_line_r;
        get_col_r  <= rd_col_r;
      end
      if (slot_free && !free_r) begin
        free_idx_r <= chk_idx_r;
      end
    end

    if (pop_ok && !needs_scan) begin
      out_data_r <= imm_res;
    end else if (state_r == ST_FIN) begin
      out_data_r <= fin_res;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      name_mem[mem_waddr] <= cmd_r.mark_name;
      line_mem[mem_waddr] <= cmd_line;
      col_mem[mem_waddr]  <= cmd_col;
    end
    rd_name_r <= name_mem[rd_idx_r];
    rd_line_r <= line_mem[rd_idx_r];
    rd_col_r  <= col_mem[rd_idx_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
